// File: rtl/psvg_pkg.sv
package psvg_pkg;

  localparam int unsigned DEF_MAX_VERTICES = 63;
  localparam int unsigned DEF_ANGLE_BITS   = 16;

  // Coordinate and vector formats
  localparam int unsigned CW           = 16;   // pixel coordinate
  localparam int unsigned SIDES_W      = 6;
  localparam int unsigned FRAC         = 12;   // fractional bits of relative vectors
  localparam int unsigned DW           = 34;   // CORDIC datapath width
  localparam int unsigned CORDIC_ITERS = 20;
  localparam int unsigned IT_W         = 5;

  // Gain removal and placement
  localparam int unsigned LO_W        = 17;    // low slice of a split operand
  localparam int unsigned OP_W        = 18;    // signed multiplier operand
  localparam int unsigned GAIN_W      = 30;
  localparam int unsigned PROD_W      = OP_W + GAIN_W;
  localparam int unsigned PLACE_SHIFT = FRAC + 30;
  localparam int unsigned ACC_W       = 66;
  localparam logic signed [GAIN_W-1:0] INV_GAIN2 = 30'sd395948877;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VEC_OUT,
    ST_VEC_IN,
    ST_DIV,
    ST_ROT,
    ST_PLACE,
    ST_EMIT,
    ST_CLOSE
  } psvg_state_e;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_cmd_t;

  // Arctangent of 2^-i in 2^32 units of a turn, rounded half up to ab bits
  function automatic logic [31:0] atan_step(input logic [IT_W-1:0] i, input int unsigned ab);
    logic [32:0] t;
    logic [32:0] s;
    case (i)
      5'd0:    t = 33'h020000000;
      5'd1:    t = 33'h012E4051E;
      5'd2:    t = 33'h009FB385B;
      5'd3:    t = 33'h0051111D4;
      5'd4:    t = 33'h0028B0D43;
      5'd5:    t = 33'h00145D7E1;
      5'd6:    t = 33'h000A2F61E;
      5'd7:    t = 33'h000517C55;
      5'd8:    t = 33'h00028BE53;
      5'd9:    t = 33'h000145F2F;
      5'd10:   t = 33'h0000A2F98;
      5'd11:   t = 33'h0000517CC;
      5'd12:   t = 33'h000028BE6;
      5'd13:   t = 33'h0000145F3;
      5'd14:   t = 33'h00000A2FA;
      5'd15:   t = 33'h00000517D;
      5'd16:   t = 33'h0000028BE;
      5'd17:   t = 33'h00000145F;
      5'd18:   t = 33'h000000A30;
      5'd19:   t = 33'h000000518;
      default: t = 33'h0;
    endcase
    s = t + (33'd1 << (31 - ab));
    return 32'(s >> (32 - ab));
  endfunction

endpackage

// File: rtl/psvg_cordic.sv
module psvg_cordic import psvg_pkg::*; #(
  parameter int unsigned ANGLE_BITS = DEF_ANGLE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cordic_cmd_t                  cmd_i,
  input  logic signed [DW-1:0]         x_i,
  input  logic signed [DW-1:0]         y_i,
  input  logic signed [ANGLE_BITS+1:0] z_i,
  output logic                         done_o,
  output logic signed [DW-1:0]         x_o,
  output logic signed [DW-1:0]         y_o,
  output logic signed [ANGLE_BITS+1:0] z_o
);

  localparam int unsigned ZW = ANGLE_BITS + 2;

  logic signed [DW-1:0] x_q, y_q, x_d, y_d, ax, ay;
  logic signed [ZW-1:0] z_q, z_d, t;
  logic [IT_W-1:0]      iter_q;
  logic                 busy_q, done_q, mode_q, up;

  // One micro-rotation per cycle; floor shifts on both axes
  always_comb begin
    ax = y_q >>> iter_q;
    ay = x_q >>> iter_q;
    t  = signed'(ZW'(atan_step(iter_q, ANGLE_BITS)));
    // vectoring drives y to zero, rotation drives the residual angle to zero
    up = mode_q ? !y_q[DW-1] : z_q[ZW-1];
    if (up) begin
      x_d = x_q + ax;
      y_d = y_q - ay;
      z_d = z_q + t;
    end else begin
      x_d = x_q - ax;
      y_d = y_q + ay;
      z_d = z_q - t;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      done_q <= busy_q && (iter_q == IT_W'(CORDIC_ITERS - 1));
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        iter_q <= '0;
      end else if (busy_q) begin
        iter_q <= iter_q + 1'b1;
        if (iter_q == IT_W'(CORDIC_ITERS - 1)) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      x_q    <= x_i;
      y_q    <= y_i;
      z_q    <= z_i;
      mode_q <= cmd_i.vec_mode;
    end else if (busy_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// File: rtl/psvg_place.sv
module psvg_place import psvg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [DW-1:0] rx_i,
  input  logic signed [DW-1:0] ry_i,
  input  logic signed [CW-1:0] cx_i,
  input  logic signed [CW-1:0] cy_i,
  output logic                 done_o,
  output logic signed [CW-1:0] vx_o,
  output logic signed [CW-1:0] vy_o
);

  localparam int unsigned SV_W = ACC_W - PLACE_SHIFT;

  logic signed [DW-1:0]     rx_q, ry_q, rel;
  logic signed [CW-1:0]     cx_q, cy_q, cen;
  logic signed [CW-1:0]     vx_q, vy_q, sat;
  logic signed [ACC_W-1:0]  acc_q, acc_d, base, prod_ext;
  logic signed [OP_W-1:0]   op;
  logic signed [PROD_W-1:0] prod;
  logic signed [SV_W-1:0]   sv;
  logic [2:0]               step_q;
  logic                     busy_q, done_q;

  // Steps: 0 low x, 1 high x, 2 low y, 3 high y, 4 finish
  always_comb begin
    rel  = step_q[1] ? ry_q : rx_q;
    cen  = step_q[1] ? cy_q : cx_q;
    if (step_q[0]) op = OP_W'(signed'(rel[DW-1:LO_W]));
    else           op = signed'({1'b0, rel[LO_W-1:0]});
    prod     = op * INV_GAIN2;
    prod_ext = ACC_W'(prod);
    base     = (ACC_W'(cen) <<< PLACE_SHIFT) + (ACC_W'(1) <<< (PLACE_SHIFT - 1));
    if (step_q[0]) acc_d = acc_q + (prod_ext <<< LO_W);
    else           acc_d = base + prod_ext;
    // floor shift then clamp to the pixel range
    sv = acc_q[ACC_W-1:PLACE_SHIFT];
    if (sv > SV_W'(32767))       sat = 16'sh7FFF;
    else if (sv < -SV_W'(32768)) sat = -16'sh8000;
    else                         sat = sv[CW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= busy_q && (step_q == 3'd4);
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == 3'd4) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rx_q <= rx_i;
      ry_q <= ry_i;
      cx_q <= cx_i;
      cy_q <= cy_i;
    end else if (busy_q) begin
      if (step_q != 3'd4) acc_q <= acc_d;
      if (step_q == 3'd2) vx_q <= sat;
      if (step_q == 3'd4) vy_q <= sat;
    end
  end

  assign done_o = done_q;
  assign vx_o   = vx_q;
  assign vy_o   = vy_q;

endmodule

// File: rtl/polygon_star_vertex_generator_top.sv
// Channel  | Dir | Word contents (lowest bit first)                         | Last / user
// ---------+-----+----------------------------------------------------------+----------------
// s_axis   | in  | center_x, center_y, outer_x, outer_y, inner_x, inner_y,  | tuser: star_mode
//          |     | sides (6b), zero pad to 104 bits                          |
// m_axis   | out | vertex_x, vertex_y                                       | tuser: is_closing
//          |     |                                                          | tlast: last
//
// For each accepted word, m being the vertex count (n, or 2n for a star), one shared
// 20-step CORDIC unit does the vectoring pass (a second one for a star's inner point)
// and one rotation per vertex, a split multiplier removes the double gain in four steps
// and the vertex is then emitted. Output stalls hold the sequencer in its emit and close
// states. Reset clears the sequencer and the output valid.
// s_axis_tready is high only in idle; the output register holds the closing word meanwhile.
module polygon_star_vertex_generator_top import psvg_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned ANGLE_BITS   = DEF_ANGLE_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,   // center_x, center_y, outer_x, outer_y, inner_x,
                                       // inner_y, sides, pad
  input  logic         s_axis_tuser,   // star_mode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata,   // vertex_x, vertex_y
  output logic         m_axis_tuser,   // is_closing
  output logic         m_axis_tlast    // last
);

  localparam int unsigned ZW    = ANGLE_BITS + 2;
  localparam int unsigned DC_W  = $clog2(ANGLE_BITS + 1);
  localparam logic [SIDES_W-1:0] CAP_POLY = SIDES_W'(MAX_VERTICES);
  localparam logic [SIDES_W-1:0] CAP_STAR = SIDES_W'(MAX_VERTICES / 2);
  localparam logic signed [ZW-1:0] HALF    = ZW'(1) <<< (ANGLE_BITS - 1);
  localparam logic signed [ZW-1:0] QUARTER = ZW'(1) <<< (ANGLE_BITS - 2);

  psvg_state_e state_q, state_d;
  logic        kick_q;

  // Shape registers
  logic signed [CW-1:0]  cx_q, cy_q, ox_q, oy_q, ix_q, iy_q;
  logic                  star_q;
  logic [SIDES_W-1:0]    m_q, n_sat, n_lo, m_new;
  logic signed [DW-1:0]  r_out_q, r_in_q;
  logic [ANGLE_BITS-1:0] theta0_q;

  // Step-angle divider and accumulator
  logic [SIDES_W-1:0]    drem_q, drem_d;
  logic [DC_W-1:0]       dcnt_q;
  logic [ANGLE_BITS-1:0] quo_q, q_step_q, ak_q, ak_d;
  logic [SIDES_W:0]      remsh, r_step_q;
  logic [SIDES_W+1:0]    arem_q, arem_sum, two_m;
  logic                  dge, div_last, acarry;

  // Vertex loop
  logic [SIDES_W-1:0]    k_q;
  logic                  first_q, last_vertex, dup, out_free, emit_now;
  logic signed [CW-1:0]  fx_q, fy_q, lx_q, ly_q;

  // Output register
  logic                  m_valid_q, m_close_q;
  logic signed [CW-1:0]  m_x_q, m_y_q;

  // Shared units
  cordic_cmd_t           ccmd;
  logic signed [DW-1:0]  cx0, cy0, c_xo, c_yo, vsx, vsy, r_sel;
  logic signed [ZW-1:0]  cz0, c_zo, sa;
  logic [ANGLE_BITS-1:0] th;
  logic signed [16:0]    dvx, dvy;
  logic                  c_done, p_done, accept;
  logic signed [CW-1:0]  p_vx, p_vy;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // Saturate the side count for the mode, then double it for stars
  always_comb begin
    n_lo  = (s_axis_tdata[101:96] < SIDES_W'(3)) ? SIDES_W'(3) : s_axis_tdata[101:96];
    n_sat = n_lo;
    if (s_axis_tuser && n_lo > CAP_STAR)  n_sat = CAP_STAR;
    if (!s_axis_tuser && n_lo > CAP_POLY) n_sat = CAP_POLY;
    m_new = s_axis_tuser ? {n_sat[SIDES_W-2:0], 1'b0} : n_sat;
  end

  // CORDIC operand preparation: fold into the right half-plane or quarter turn
  always_comb begin
    if (state_q == ST_VEC_IN) begin
      dvx = {ix_q[CW-1], ix_q} - {cx_q[CW-1], cx_q};
      dvy = {iy_q[CW-1], iy_q} - {cy_q[CW-1], cy_q};
    end else begin
      dvx = {ox_q[CW-1], ox_q} - {cx_q[CW-1], cx_q};
      dvy = {oy_q[CW-1], oy_q} - {cy_q[CW-1], cy_q};
    end
    vsx = DW'(dvx) <<< FRAC;
    vsy = DW'(dvy) <<< FRAC;

    th    = theta0_q + ak_q;
    sa    = ZW'(signed'(th));
    r_sel = (star_q && k_q[0]) ? r_in_q : r_out_q;

    ccmd.start    = kick_q && (state_q == ST_VEC_OUT || state_q == ST_VEC_IN ||
                               state_q == ST_ROT);
    ccmd.vec_mode = (state_q != ST_ROT);

    if (state_q == ST_ROT) begin
      cy0 = '0;
      if (sa > QUARTER) begin
        cx0 = -r_sel;
        cz0 = sa - HALF;
      end else if (sa < -QUARTER) begin
        cx0 = -r_sel;
        cz0 = sa + HALF;
      end else begin
        cx0 = r_sel;
        cz0 = sa;
      end
    end else if (vsx[DW-1]) begin
      cx0 = -vsx;
      cy0 = -vsy;
      cz0 = HALF;
    end else begin
      cx0 = vsx;
      cy0 = vsy;
      cz0 = '0;
    end
  end

  psvg_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (ccmd),
    .x_i    (cx0),
    .y_i    (cy0),
    .z_i    (cz0),
    .done_o (c_done),
    .x_o    (c_xo),
    .y_o    (c_yo),
    .z_o    (c_zo)
  );

  psvg_place u_place (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (kick_q && state_q == ST_PLACE),
    .rx_i    (c_xo),
    .ry_i    (c_yo),
    .cx_i    (cx_q),
    .cy_i    (cy_q),
    .done_o  (p_done),
    .vx_o    (p_vx),
    .vy_o    (p_vy)
  );

  // Restoring division of one turn by m, one quotient bit a cycle
  always_comb begin
    remsh    = {drem_q, (dcnt_q == '0)};
    dge      = remsh >= {1'b0, m_q};
    drem_d   = dge ? SIDES_W'(remsh - {1'b0, m_q}) : remsh[SIDES_W-1:0];
    div_last = !kick_q && (dcnt_q == DC_W'(ANGLE_BITS));

    // Step angle a_k = round(k * turn / m): add quotient, carry the remainder
    two_m    = {1'b0, m_q, 1'b0};
    arem_sum = arem_q + {1'b0, r_step_q};
    acarry   = arem_sum >= two_m;
    ak_d     = ak_q + q_step_q + ANGLE_BITS'(acarry);
  end

  // Sequencer
  always_comb begin
    out_free    = !m_valid_q || m_axis_tready;
    dup         = !first_q && (p_vx == lx_q) && (p_vy == ly_q);
    emit_now    = (state_q == ST_EMIT) && (dup || out_free);
    last_vertex = (k_q == m_q - 1'b1);
    state_d     = state_q;
    unique case (state_q)
      ST_IDLE:    if (accept) state_d = ST_VEC_OUT;
      ST_VEC_OUT: if (c_done) state_d = star_q ? ST_VEC_IN : ST_DIV;
      ST_VEC_IN:  if (c_done) state_d = ST_DIV;
      ST_DIV:     if (div_last) state_d = ST_ROT;
      ST_ROT:     if (c_done) state_d = ST_PLACE;
      ST_PLACE:   if (p_done) state_d = ST_EMIT;
      ST_EMIT:    if (emit_now) state_d = last_vertex ? ST_CLOSE : ST_ROT;
      ST_CLOSE:   if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      kick_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // launch the unit of a state on its first cycle
      kick_q  <= (state_d != state_q);
      if ((emit_now && !dup) || (state_q == ST_CLOSE && out_free)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cx_q   <= s_axis_tdata[15:0];
      cy_q   <= s_axis_tdata[31:16];
      ox_q   <= s_axis_tdata[47:32];
      oy_q   <= s_axis_tdata[63:48];
      ix_q   <= s_axis_tdata[79:64];
      iy_q   <= s_axis_tdata[95:80];
      star_q <= s_axis_tuser;
      m_q    <= m_new;
    end
    if (state_q == ST_VEC_OUT && c_done) begin
      r_out_q  <= c_xo;
      theta0_q <= c_zo[ANGLE_BITS-1:0];
    end
    if (state_q == ST_VEC_IN && c_done) r_in_q <= c_xo;

    if (state_q == ST_DIV) begin
      if (kick_q) begin
        drem_q <= '0;
        dcnt_q <= '0;
        quo_q  <= '0;
      end else begin
        drem_q <= drem_d;
        dcnt_q <= dcnt_q + 1'b1;
        quo_q  <= {quo_q[ANGLE_BITS-2:0], dge};
      end
      if (div_last) begin
        q_step_q <= {quo_q[ANGLE_BITS-2:0], dge};
        r_step_q <= {drem_d, 1'b0};
        ak_q     <= '0;
        arem_q   <= {2'b00, m_q};
        k_q      <= '0;
        first_q  <= 1'b1;
      end
    end

    if (emit_now) begin
      if (!dup) begin
        lx_q    <= p_vx;
        ly_q    <= p_vy;
        first_q <= 1'b0;
        if (first_q) begin
          fx_q <= p_vx;
          fy_q <= p_vy;
        end
      end
      k_q    <= k_q + 1'b1;
      ak_q   <= ak_d;
      arem_q <= acarry ? arem_sum - two_m : arem_sum;
    end

    // Load the output word
    if (emit_now && !dup) begin
      m_x_q     <= p_vx;
      m_y_q     <= p_vy;
      m_close_q <= 1'b0;
    end else if (state_q == ST_CLOSE && out_free) begin
      m_x_q     <= fx_q;
      m_y_q     <= fy_q;
      m_close_q <= 1'b1;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_y_q, m_x_q};
  assign m_axis_tuser  = m_close_q;
  assign m_axis_tlast  = m_close_q;

  // Checks
  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
    else $error("closing word without last");

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROT) |-> (k_q < m_q))
    else $error("vertex index beyond count");

  a_m_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (m_q >= SIDES_W'(3) && m_q <= CAP_POLY))
    else $error("vertex count out of range");

  a_cordic_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_done |-> (state_q == ST_VEC_OUT || state_q == ST_VEC_IN || state_q == ST_ROT))
    else $error("CORDIC finished outside a CORDIC state");

endmodule

// File: test/tb_polygon_star_vertex_generator_top.sv
module tb_polygon_star_vertex_generator_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint RUN_LIMIT  = 4_000_000;
  localparam int     N_RANDOM   = 450;
  localparam int     HOLD_LEN   = 400;
  localparam int     DRAIN_WAIT = 200;

  typedef struct {
    logic [15:0] cx, cy, ox, oy, ix, iy;
    logic [5:0]  sides;
    logic        star;
  } shape_t;

  typedef struct {
    logic [15:0] vx, vy;
    logic        closing, last;
  } vertex_t;

  // Directed row: expected vertex typed in only for zero-radius shapes
  typedef struct {
    shape_t      shp;
    logic        typed;
    logic [15:0] ex, ey;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;  // center_x, center_y, outer_x, outer_y, inner_x,
                                    // inner_y, sides, pad
  logic         s_axis_tuser = 1'b0; // star_mode
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [31:0]  m_axis_tdata;       // vertex_x, vertex_y
  logic         m_axis_tuser;       // is_closing
  logic         m_axis_tlast;       // last

  vertex_t vertex_q[$];
  int      n_errors = 0;
  int      sender_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    hold_go = 1'b0;
  logic    hold_done = 1'b0;
  int      hold_cnt = 0;
  longint  cycle_cnt = 0;

  polygon_star_vertex_generator_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Guard against a hung block
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Outline predictor: vectoring and rotation in fixed point
  // ---------------------------------------------------------------------

  // Arctangent of 2^-i in 2^32 units of a turn, rounded half up to 16 bits
  function automatic longint arc_step(input int i);
    longint t;
    case (i)
      0:  t = 64'h20000000;  1:  t = 64'h12E4051E;  2:  t = 64'h09FB385B;
      3:  t = 64'h051111D4;  4:  t = 64'h028B0D43;  5:  t = 64'h0145D7E1;
      6:  t = 64'h00A2F61E;  7:  t = 64'h00517C55;  8:  t = 64'h0028BE53;
      9:  t = 64'h00145F2F;  10: t = 64'h000A2F98;  11: t = 64'h000517CC;
      12: t = 64'h00028BE6;  13: t = 64'h000145F3;  14: t = 64'h0000A2FA;
      15: t = 64'h0000517D;  16: t = 64'h000028BE;  17: t = 64'h0000145F;
      18: t = 64'h00000A30;  default: t = 64'h00000518;
    endcase
    return (t + 64'd32768) >> 16;
  endfunction

  task automatic measure_vector(input longint x0, input longint y0,
                                output longint mag, output longint ang);
    longint x, y, z, ax, ay, t;
    x = x0;
    y = y0;
    z = 0;
    // turn by half a turn when pointing left
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32768;
    end
    for (int i = 0; i < 20; i++) begin
      ax = y >>> i;
      ay = x >>> i;
      t  = arc_step(i);
      if (y >= 0) begin
        x += ax; y -= ay; z += t;
      end else begin
        x -= ax; y += ay; z -= t;
      end
    end
    mag = x;
    ang = z & 64'hFFFF;
  endtask

  task automatic turn_radius(input longint r, input longint a,
                             output longint ox, output longint oy);
    longint x, y, sa, ax, ay, t;
    x  = r;
    y  = 0;
    sa = a & 64'hFFFF;
    if (sa >= 32768) sa -= 65536;
    // fold into a quarter turn either side of zero
    if (sa > 16384) begin
      x = -x; sa -= 32768;
    end else if (sa < -16384) begin
      x = -x; sa += 32768;
    end
    for (int i = 0; i < 20; i++) begin
      ax = y >>> i;
      ay = x >>> i;
      t  = arc_step(i);
      if (sa >= 0) begin
        x -= ax; y += ay; sa -= t;
      end else begin
        x += ax; y -= ay; sa += t;
      end
    end
    ox = x;
    oy = y;
  endtask

  function automatic logic [15:0] place_coord(input longint rel, input longint c);
    longint acc, v;
    acc = rel * 64'sd395948877 + (c <<< 42) + (64'sd1 <<< 41);
    v   = acc >>> 42;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic predict_outline(input shape_t s);
    longint cx, cy, dx, dy, ix, iy, r_out, r_in, th0, dummy, r, rx, ry;
    longint unsigned ak;
    int n, cap, m, cnt;
    logic [15:0] vx, vy, fx, fy, lx, ly;
    vertex_t v;
    cx = longint'(signed'(s.cx));
    cy = longint'(signed'(s.cy));
    dx = (longint'(signed'(s.ox)) - cx) <<< 12;
    dy = (longint'(signed'(s.oy)) - cy) <<< 12;
    ix = (longint'(signed'(s.ix)) - cx) <<< 12;
    iy = (longint'(signed'(s.iy)) - cy) <<< 12;
    n   = s.sides;
    cap = s.star ? 31 : 63;
    r_in = 0;
    cnt  = 0;
    fx = '0; fy = '0; lx = '0; ly = '0;
    if (n < 3) n = 3;
    if (n > cap) n = cap;
    m = s.star ? 2 * n : n;
    measure_vector(dx, dy, r_out, th0);
    if (s.star) measure_vector(ix, iy, r_in, dummy);
    for (int k = 0; k < m; k++) begin
      ak = ((longint'(k) << 17) + m) / (2 * m);
      r  = (s.star && k[0]) ? r_in : r_out;
      turn_radius(r, (th0 + longint'(ak)) & 64'hFFFF, rx, ry);
      vx = place_coord(rx, cx);
      vy = place_coord(ry, cy);
      // drop a vertex that repeats the one before it
      if (cnt > 0 && vx == lx && vy == ly) continue;
      if (cnt == 0) begin
        fx = vx; fy = vy;
      end
      v = '{vx, vy, 1'b0, 1'b0};
      vertex_q.push_back(v);
      lx = vx; ly = vy;
      cnt++;
    end
    v = '{fx, fy, 1'b1, 1'b1};
    vertex_q.push_back(v);
  endtask

  // ---------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------
  task automatic offer_shape(input shape_t s, input logic typed,
                             input logic [15:0] ex, input logic [15:0] ey);
    vertex_t v;
    s_axis_tdata  <= {2'b00, s.sides, s.iy, s.ix, s.oy, s.ox, s.cy, s.cx};
    s_axis_tuser  <= s.star;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (typed) begin
      v = '{ex, ey, 1'b0, 1'b0};
      vertex_q.push_back(v);
      v = '{ex, ey, 1'b1, 1'b1};
      vertex_q.push_back(v);
    end else begin
      predict_outline(s);
    end
    // idle the sender for a while, or keep valid up for the next word
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  endtask

  function automatic logic [15:0] near(input logic [15:0] c);
    return c + 16'($urandom_range(0, 4000)) - 16'd2000;
  endfunction

  function automatic shape_t random_shape();
    shape_t s;
    int pick;
    pick    = $urandom_range(99);
    s.cx    = 16'($urandom);
    s.cy    = 16'($urandom);
    s.star  = 1'($urandom);
    s.sides = ($urandom_range(99) < 75) ? 6'($urandom_range(0, 12)) : 6'($urandom);
    if (pick < 60) begin
      s.ox = near(s.cx); s.oy = near(s.cy);
      s.ix = near(s.cx); s.iy = near(s.cy);
    end else if (pick < 72) begin
      // tiny radius: vertices collapse and repeats drop out
      s.ox = s.cx + 16'($urandom_range(0, 2)); s.oy = s.cy;
      s.ix = s.cx; s.iy = s.cy + 16'($urandom_range(0, 1));
    end else begin
      s.ox = 16'($urandom); s.oy = 16'($urandom);
      s.ix = 16'($urandom); s.iy = 16'($urandom);
    end
    return s;
  endfunction

  initial begin
    dir_row_t dir_tab[$];
    shape_t   s;
    int       phase, prev_phase;
    // zero radius at zero and at both coordinate extremes, outline collapses to the centre
    dir_tab.push_back('{'{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                          6'd3, 1'b0}, 1'b1, 16'h0000, 16'h0000});
    dir_tab.push_back('{'{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                          6'd63, 1'b1}, 1'b1, 16'h7FFF, 16'h7FFF});
    dir_tab.push_back('{'{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          6'd0, 1'b0}, 1'b1, 16'h8000, 16'h8000});
    dir_tab.push_back('{'{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                          6'd17, 1'b1}, 1'b1, 16'h8000, 16'h7FFF});
    // side counts below three, at the caps of either mode and above the star cap
    dir_tab.push_back('{'{16'h0000, 16'h0000, 16'd100, 16'h0000, 16'h0000, 16'h0000,
                          6'd0, 1'b0}, 1'b0, 16'h0, 16'h0});
    dir_tab.push_back('{'{16'h0000, 16'h0000, 16'd100, 16'd40, 16'h0000, 16'h0000,
                          6'd1, 1'b0}, 1'b0, 16'h0, 16'h0});
    dir_tab.push_back('{'{16'd50, 16'd50, 16'd150, 16'd50, 16'h0000, 16'h0000,
                          6'd2, 1'b1}, 1'b0, 16'h0, 16'h0});
    dir_tab.push_back('{'{16'd10, 16'd20, 16'd1010, 16'd520, 16'hFFFF, 16'hFFFF,
                          6'd63, 1'b0}, 1'b0, 16'h0, 16'h0});
    dir_tab.push_back('{'{16'd10, 16'd20, 16'd1010, 16'd520, 16'd300, 16'd20,
                          6'd31, 1'b1}, 1'b0, 16'h0, 16'h0});
    dir_tab.push_back('{'{16'd10, 16'd20, 16'd1010, 16'd520, 16'd300, 16'd20,
                          6'd32, 1'b1}, 1'b0, 16'h0, 16'h0});
    dir_tab.push_back('{'{16'd10, 16'd20, 16'd10, 16'd900, 16'd40, 16'd20,
                          6'd63, 1'b1}, 1'b0, 16'h0, 16'h0});
    // outer point to the left of the centre
    dir_tab.push_back('{'{16'h0000, 16'h0000, -16'sd500, 16'd30, 16'h0000, 16'h0000,
                          6'd5, 1'b0}, 1'b0, 16'h0, 16'h0});
    // widest spans: vertices saturate; last, a one-pixel radius with 63 sides
    dir_tab.push_back('{'{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                          6'd6, 1'b1}, 1'b0, 16'h0, 16'h0});
    dir_tab.push_back('{'{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'h0000,
                          6'd8, 1'b0}, 1'b0, 16'h0, 16'h0});
    dir_tab.push_back('{'{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF,
                          6'h3F, 1'b0}, 1'b0, 16'h0, 16'h0});
    // inner point ignored in polygon mode; inner at the centre in star mode
    dir_tab.push_back('{'{16'd0, 16'd0, 16'd200, 16'd0, 16'h8000, 16'h7FFF,
                          6'd4, 1'b0}, 1'b0, 16'h0, 16'h0});
    dir_tab.push_back('{'{16'd0, 16'd0, 16'd200, 16'd0, 16'd0, 16'd0,
                          6'd5, 1'b1}, 1'b0, 16'h0, 16'h0});
    // inner radius larger than the outer one
    dir_tab.push_back('{'{16'd0, 16'd0, 16'd0, 16'd60, 16'd900, 16'd0,
                          6'd7, 1'b1}, 1'b0, 16'h0, 16'h0});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i])
      offer_shape(dir_tab[i].shp, dir_tab[i].typed, dir_tab[i].ex, dir_tab[i].ey);

    prev_phase = -1;
    for (int i = 0; i < N_RANDOM; i++) begin
      phase = i * 4 / N_RANDOM;
      if (phase != prev_phase) begin
        // hold the sender until the outline in flight has drained
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (vertex_q.size() != 0) @(posedge clk_i);
        case (phase)
          0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
          1:       begin sender_idle_pct = 55; recv_stall_pct = 0;  end
          2:       begin sender_idle_pct = 0;  recv_stall_pct = 55; end
          default: begin sender_idle_pct = 18; recv_stall_pct = 18; end
        endcase
        prev_phase = phase;
      end
      // long receiver hold-off while shapes keep coming
      if (i == 60) hold_go = 1'b1;
      s = random_shape();
      offer_shape(s, 1'b0, 16'h0, 16'h0);
    end
    s_axis_tvalid <= 1'b0;

    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // Receiver: random stalls plus one long hold-off
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt      <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_cnt      <= HOLD_LEN;
      hold_done     <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each accepted word with the oldest expected vertex
  always @(posedge clk_i) begin
    vertex_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (vertex_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected word x=%0d y=%0d closing=%0b last=%0b", $realtime,
                 $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                 m_axis_tuser, m_axis_tlast);
      end else begin
        e = vertex_q.pop_front();
        if (m_axis_tdata[15:0] !== e.vx || m_axis_tdata[31:16] !== e.vy ||
            m_axis_tuser !== e.closing || m_axis_tlast !== e.last) begin
          n_errors++;
          $display("%0t: expected x=%0d y=%0d closing=%0b last=%0b, got x=%0d y=%0d closing=%0b last=%0b",
                   $realtime, $signed(e.vx), $signed(e.vy), e.closing, e.last,
                   $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                   m_axis_tuser, m_axis_tlast);
        end
      end
    end
  end

endmodule
